>>> rtl/gbn_pkg.sv
// Shared types and constants for the go-back-n sender window.
`default_nettype none
package gbn_pkg;

	localparam int SEQ_SPACE = 8;
	localparam int SEQ_W     = $clog2(SEQ_SPACE);
	localparam int PAY_W     = 32;
	localparam int CNT_W     = 3;
	localparam int LIMIT_W   = 3;
	localparam int MAX_CNT   = SEQ_SPACE - 1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4);

	// operation codes
	localparam logic [1:0] OP_SEND    = 2'd0;
	localparam logic [1:0] OP_ACK     = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	// result kinds
	localparam logic [2:0] KIND_SENT     = 3'd0;
	localparam logic [2:0] KIND_REFUSED  = 3'd1;
	localparam logic [2:0] KIND_ACK_OK   = 3'd2;
	localparam logic [2:0] KIND_ACK_OLD  = 3'd3;
	localparam logic [2:0] KIND_ACK_BAD  = 3'd4;
	localparam logic [2:0] KIND_RETX     = 3'd5;
	localparam logic [2:0] KIND_IDLE_TMO = 3'd6;

	// timer actions
	localparam logic [1:0] TMR_NONE    = 2'd0;
	localparam logic [1:0] TMR_START   = 2'd1;
	localparam logic [1:0] TMR_STOP    = 2'd2;
	localparam logic [1:0] TMR_RESTART = 2'd3;

	typedef struct packed {
		logic [1:0]       operation;
		logic [PAY_W-1:0] payload;
		logic [SEQ_W-1:0] ack_number;
		logic             ack_checksum_ok;
	} req_t;

	typedef struct packed {
		logic [2:0]       result_kind;
		logic [SEQ_W-1:0] packet_seq;
		logic [PAY_W-1:0] packet_payload;
		logic [1:0]       timer_action;
		logic [SEQ_W-1:0] timer_seq;
		logic [CNT_W-1:0] outstanding;
		logic             last;
	} rsp_t;

	// operands for the shared sequence-number unit
	typedef struct packed {
		logic [SEQ_W-1:0] a;
		logic [SEQ_W-1:0] b;
		logic [SEQ_W-1:0] c;
		logic             sub;
	} alu_op_t;

	typedef struct packed {
		logic [SEQ_W-1:0] y;
		logic             lt;
		logic             zero;
	} alu_res_t;

endpackage
`default_nettype wire

>>> rtl/gbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gbn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/gbn_seq_alu.sv
// Shared modulo sequence-number adder/subtractor with compare and zero flag.
`default_nettype none
module gbn_seq_alu (
	input  wire gbn_pkg::alu_op_t  op,
	output gbn_pkg::alu_res_t      res
);

	logic [gbn_pkg::SEQ_W-1:0] sum;

	// wraps naturally modulo the sequence space
	assign sum      = op.sub ? (op.a - op.b) : (op.a + op.b);
	assign res.y    = sum;
	assign res.lt   = (sum < op.c);
	assign res.zero = (sum == '0);

endmodule
`default_nettype wire

>>> rtl/go_back_n_sender_window_unit.sv
// Top level of the go-back-n sender window: sequencer, state and result path.
`default_nettype none
// Go-back-n ARQ sender window.
// Request channel: a request (send, ack arrived, timer expired) is taken at a
// rising edge with start high and busy low; busy stays high while it is
// worked on and start is ignored meanwhile.
// Result channel: each result sits on "result" for exactly one cycle with
// result_valid high; the receiver cannot stall it. The final result of a
// request carries last = 1. An unknown operation gives no result.
// Config channel: cfg_data (window limit) is written on cfg_valid & cfg_ready;
// cfg_ready is always high. Write it only while the block is idle.
// Flow of a request after it is taken:
//   send, refused send, corrupt or stale ack, idle timeout, unknown op:
//   one execute step, then the result (if any) from the result register.
//   ack inside the window: three passes through the shared sequence unit
//   (offset, new base, new count), then the result.
//   timeout with n outstanding packets: one RAM read per cycle, one result
//   per packet from the base onward. In every case the next request can be
//   taken while the final result (if any) is shown.
// Reset: base = next = 0, window limit = 4, no result pending; the payload
// RAM is not cleared, only written slots are ever replayed.
module go_back_n_sender_window_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire gbn_pkg::req_t                 req,
	output logic                               result_valid,
	output gbn_pkg::rsp_t                      result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [gbn_pkg::LIMIT_W-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SLIDE,
		ST_RECOUNT,
		ST_REPLAY
	} state_t;

	state_t                      state_q;
	gbn_pkg::req_t               req_q;
	gbn_pkg::rsp_t               rsp_q;
	logic                        valid_q;
	logic [gbn_pkg::SEQ_W-1:0]   base_q;
	logic [gbn_pkg::SEQ_W-1:0]   next_q;
	logic [gbn_pkg::CNT_W-1:0]   cnt_q;
	logic [gbn_pkg::LIMIT_W-1:0] limit_q;
	logic [gbn_pkg::SEQ_W-1:0]   old_base_q;
	logic [gbn_pkg::SEQ_W-1:0]   ptr_q;
	logic [gbn_pkg::CNT_W-1:0]   remain_q;
	logic                        first_q;

	// replay read stage, lined up with the RAM read data
	logic                        repl_vld_s1;
	logic [gbn_pkg::SEQ_W-1:0]   seq_s1;
	logic                        first_s1;
	logic                        last_s1;

	gbn_pkg::alu_op_t            alu_op;
	gbn_pkg::alu_res_t           alu_res;
	logic                        refuse;
	logic                        ram_we;
	logic [gbn_pkg::PAY_W-1:0]   ram_rdata;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// window full: at the limit, or every sequence number but one in flight
	assign refuse = (cnt_q >= gbn_pkg::CNT_W'(limit_q)) ||
	                (cnt_q >= gbn_pkg::CNT_W'(gbn_pkg::MAX_CNT));

	assign ram_we = (state_q == ST_EXEC) && (req_q.operation == gbn_pkg::OP_SEND) && !refuse;

	// operand select for the shared unit
	always_comb begin
		alu_op.a   = next_q;
		alu_op.b   = gbn_pkg::SEQ_W'(1);
		alu_op.c   = gbn_pkg::SEQ_W'(cnt_q);
		alu_op.sub = 1'b0;
		unique case (state_q)
			ST_EXEC: begin
				if (req_q.operation == gbn_pkg::OP_ACK) begin
					// offset of the ack number from the base
					alu_op.a   = req_q.ack_number;
					alu_op.b   = base_q;
					alu_op.sub = 1'b1;
				end
			end
			ST_SLIDE: begin
				alu_op.a = req_q.ack_number;
			end
			ST_RECOUNT: begin
				alu_op.a   = next_q;
				alu_op.b   = base_q;
				alu_op.sub = 1'b1;
			end
			ST_REPLAY: begin
				alu_op.a = ptr_q;
			end
			default: begin
			end
		endcase
	end

	gbn_seq_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	gbn_ram #(
		.WIDTH (gbn_pkg::PAY_W),
		.DEPTH (gbn_pkg::SEQ_SPACE)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (next_q),
		.wdata (req_q.payload),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= '0;
			rsp_q       <= '0;
			valid_q     <= 1'b0;
			base_q      <= '0;
			next_q      <= '0;
			cnt_q       <= '0;
			limit_q     <= gbn_pkg::LIMIT_RESET;
			old_base_q  <= '0;
			ptr_q       <= '0;
			remain_q    <= '0;
			first_q     <= 1'b0;
			repl_vld_s1 <= 1'b0;
			seq_s1      <= '0;
			first_s1    <= 1'b0;
			last_s1     <= 1'b0;
		end else begin
			valid_q     <= 1'b0;
			repl_vld_s1 <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q   <= req;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					rsp_q      <= '0;
					rsp_q.last <= 1'b1;
					state_q    <= ST_IDLE;
					case (req_q.operation)
						gbn_pkg::OP_SEND: begin
							valid_q <= 1'b1;
							if (refuse) begin
								rsp_q.result_kind <= gbn_pkg::KIND_REFUSED;
								rsp_q.outstanding <= cnt_q;
							end else begin
								next_q                <= alu_res.y;
								cnt_q                 <= cnt_q + gbn_pkg::CNT_W'(1);
								rsp_q.result_kind     <= gbn_pkg::KIND_SENT;
								rsp_q.packet_seq      <= next_q;
								rsp_q.packet_payload  <= req_q.payload;
								rsp_q.outstanding     <= cnt_q + gbn_pkg::CNT_W'(1);
								if (cnt_q == '0) begin
									rsp_q.timer_action <= gbn_pkg::TMR_START;
									rsp_q.timer_seq    <= base_q;
								end
							end
						end
						gbn_pkg::OP_ACK: begin
							if (!req_q.ack_checksum_ok) begin
								valid_q           <= 1'b1;
								rsp_q.result_kind <= gbn_pkg::KIND_ACK_BAD;
								rsp_q.outstanding <= cnt_q;
							end else if (alu_res.lt) begin
								// ack lies in the window: slide the base
								old_base_q <= base_q;
								state_q    <= ST_SLIDE;
							end else begin
								valid_q            <= 1'b1;
								rsp_q.result_kind  <= gbn_pkg::KIND_ACK_OLD;
								rsp_q.timer_action <= (cnt_q != '0) ?
								                      gbn_pkg::TMR_RESTART : gbn_pkg::TMR_STOP;
								rsp_q.timer_seq    <= base_q;
								rsp_q.outstanding  <= cnt_q;
							end
						end
						gbn_pkg::OP_TIMEOUT: begin
							if (cnt_q == '0) begin
								valid_q           <= 1'b1;
								rsp_q.result_kind <= gbn_pkg::KIND_IDLE_TMO;
							end else begin
								ptr_q    <= base_q;
								remain_q <= cnt_q;
								first_q  <= 1'b1;
								state_q  <= ST_REPLAY;
							end
						end
						default: begin
							// unknown operation: silent
						end
					endcase
				end
				ST_SLIDE: begin
					base_q  <= alu_res.y;
					state_q <= ST_RECOUNT;
				end
				ST_RECOUNT: begin
					cnt_q             <= gbn_pkg::CNT_W'(alu_res.y);
					valid_q           <= 1'b1;
					rsp_q             <= '0;
					rsp_q.last        <= 1'b1;
					rsp_q.result_kind <= gbn_pkg::KIND_ACK_OK;
					rsp_q.outstanding <= gbn_pkg::CNT_W'(alu_res.y);
					if (!alu_res.zero) begin
						rsp_q.timer_action <= gbn_pkg::TMR_RESTART;
						rsp_q.timer_seq    <= base_q;
					end else begin
						rsp_q.timer_action <= gbn_pkg::TMR_STOP;
						rsp_q.timer_seq    <= old_base_q;
					end
					state_q <= ST_IDLE;
				end
				ST_REPLAY: begin
					repl_vld_s1 <= 1'b1;
					seq_s1      <= ptr_q;
					first_s1    <= first_q;
					last_s1     <= (remain_q == gbn_pkg::CNT_W'(1));
					first_q     <= 1'b0;
					ptr_q       <= alu_res.y;
					remain_q    <= remain_q - gbn_pkg::CNT_W'(1);
					if (remain_q == gbn_pkg::CNT_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// replayed packets take their payload straight from the RAM read register
	always_comb begin
		result_valid = valid_q | repl_vld_s1;
		result       = rsp_q;
		if (repl_vld_s1) begin
			result.result_kind    = gbn_pkg::KIND_RETX;
			result.packet_seq     = seq_s1;
			result.packet_payload = ram_rdata;
			result.timer_action   = first_s1 ? gbn_pkg::TMR_RESTART : gbn_pkg::TMR_NONE;
			result.timer_seq      = first_s1 ? base_q : '0;
			result.outstanding    = cnt_q;
			result.last           = last_s1;
		end
	end

	// the two result sources never collide
	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_q && repl_vld_s1))
		else $error("result register and replay stage both valid");

	// the count register tracks next - base whenever the block is idle
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cnt_q == gbn_pkg::CNT_W'(next_q - base_q)))
		else $error("outstanding count out of step with base and next");

	// nothing is shown in the cycle right after a request is taken
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_valid)
		else $error("result shown in the cycle after accept");

	// a replay result that is not the final one keeps the block busy
	a_replay_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(repl_vld_s1 && !last_s1) |-> busy)
		else $error("block idle in the middle of a replay run");

endmodule
`default_nettype wire
